// ----- rtl/core/adaptive_size_class_table_macros.svh -----
// Assertion macros shared by the size class table RTL
`ifndef ADAPTIVE_SIZE_CLASS_TABLE_MACROS_SVH
`define ADAPTIVE_SIZE_CLASS_TABLE_MACROS_SVH

// Property that must hold at every clock outside reset
`define ASCT_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen outside reset
`define ASCT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/asct_pkg.sv -----
// Types, codes and constants of the size class table
`default_nettype none
package asct_pkg;

	localparam int DEF_MAX_CLASSES     = 256;
	localparam int DEF_SLAB_PAGE_BYTES = 4096;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_APPEND = 3'd1;
	localparam logic [2:0] OP_LOOKUP = 3'd2;
	localparam logic [2:0] OP_SIZE   = 3'd3;
	localparam logic [2:0] OP_COUNT  = 3'd4;
	localparam logic [2:0] OP_ADAPT  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	localparam logic [1:0] REG_MODE    = 2'd0;
	localparam logic [1:0] REG_HOT     = 2'd1;
	localparam logic [1:0] REG_COLD    = 2'd2;
	localparam logic [1:0] REG_QUANTUM = 2'd3;

	localparam logic [1:0] MODE_DYNAMIC  = 2'd1;
	localparam logic [1:0] MODE_ADAPTIVE = 2'd2;

	localparam logic [31:0] HOT_RESET     = 32'd10000;
	localparam logic [31:0] COLD_RESET    = 32'd10;
	localparam logic [12:0] QUANTUM_RESET = 13'd16;
	localparam logic [5:0]  LOG2_MAX      = 6'd46;
	localparam logic [12:0] REGION_MAX    = 13'd8191;

	typedef struct packed {
		logic [48:0] size;
		logic [46:0] align;
		logic [12:0] regions;
		logic [31:0] allocs;
		logic [31:0] frees;
		logic        dyn;
	} entry_t;

	typedef enum logic [2:0] {
		CK_NONE,
		CK_WRITE,
		CK_SHR,
		CK_SHL,
		CK_COUNT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     is_free;
		logic     clr_prev;
		entry_t   ent;
	} ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/asct_cell.sv -----
// One table cell: holds a class and trades it with its neighbours
`default_nettype none
module asct_cell #(
	parameter int CW    = 9,
	parameter int INDEX = 0
) (
	input  wire logic             clk,
	input  wire asct_pkg::ctl_t   ctl,
	input  wire logic [CW-1:0]    idx_a,
	input  wire logic [CW-1:0]    idx_b,
	input  wire asct_pkg::entry_t left,
	input  wire asct_pkg::entry_t right,
	output asct_pkg::entry_t      ent
);
	import asct_pkg::*;

	localparam logic [CW-1:0] MY      = CW'(INDEX);
	localparam logic [CW-1:0] MY_NEXT = CW'(INDEX + 1);

	entry_t ent_q;

	assign ent = ent_q;

	// Load, shift or count according to the broadcast command
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			CK_WRITE: begin
				if (idx_a == MY) begin
					ent_q <= ctl.ent;
				end else if (ctl.clr_prev && idx_a == MY_NEXT) begin
					ent_q.allocs <= '0;
				end
			end
			CK_SHR: begin
				if (MY > idx_a && MY <= idx_b) ent_q <= left;
			end
			CK_SHL: begin
				if (MY >= idx_a && MY < idx_b) ent_q <= right;
			end
			CK_COUNT: begin
				if (idx_a == MY) begin
					if (ctl.is_free) begin
						if (ent_q.frees != '1) ent_q.frees <= ent_q.frees + 32'd1;
					end else begin
						if (ent_q.allocs != '1) ent_q.allocs <= ent_q.allocs + 32'd1;
					end
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/core/asct_div.sv -----
// Restoring divider: slab page bytes over a midpoint size, saturated
`default_nettype none
module asct_div #(
	parameter int SLAB_PAGE_BYTES = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [48:0] divisor,
	output logic             busy,
	output logic [12:0]      regions
);
	import asct_pkg::*;

	localparam int DW   = $clog2(SLAB_PAGE_BYTES + 1);
	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   num_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   quo_q;
	logic [48:0]     div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic [DW-1:0]   remx;

	assign remx    = {rem_q[DW-2:0], num_q[DW-1]};
	assign busy    = busy_q;
	assign regions = (32'(quo_q) > 32'(REGION_MAX)) ? REGION_MAX : 13'(quo_q);

	// One quotient bit per cycle, most significant first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else if (start) begin
			num_q  <= DW'(SLAB_PAGE_BYTES);
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= divisor;
			cnt_q  <= '0;
			busy_q <= (divisor != '0);
		end else if (busy_q) begin
			if (49'(remx) >= div_q) begin
				rem_q <= remx - DW'(div_q);
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= remx;
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
			num_q <= {num_q[DW-2:0], 1'b0};
			cnt_q <= cnt_q + CNTW'(1);
			if (cnt_q == CNTW'(DW - 1)) busy_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/adaptive_size_class_table.sv -----
// Lookup runs a binary search, each step an address and a compare state; size of index reads the cell.
// Adapt walks the classes in each pass, and each midpoint inserted waits on the serial
// divider that works out the slab region count.
// One item is worked at a time; the next is taken while a result waits.
// Reset clears the class count and loads the register defaults; cells need no clearing.
`default_nettype none
`include "adaptive_size_class_table_macros.svh"
module adaptive_size_class_table #(
	parameter int MAX_CLASSES     = asct_pkg::DEF_MAX_CLASSES,
	parameter int SLAB_PAGE_BYTES = asct_pkg::DEF_SLAB_PAGE_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [48:0] request_size,
	input  wire logic [7:0]  class_slot,
	input  wire logic        event_is_free,
	input  wire logic [5:0]  base_log2,
	input  wire logic [2:0]  delta_count,
	input  wire logic [5:0]  delta_log2,
	input  wire logic        is_slab,
	input  wire logic [11:0] page_count,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [7:0]       found_index,
	output logic [48:0]      class_bytes,
	output logic [46:0]      class_alignment,
	output logic [12:0]      regions_per_slab,
	output logic [8:0]       table_entries,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import asct_pkg::*;

	localparam int IW = $clog2(MAX_CLASSES);
	localparam int CW = $clog2(MAX_CLASSES + 1);
	localparam int SW = (CW > 8) ? CW : 8;

	typedef enum logic [4:0] {
		S_IDLE, S_EXEC, S_LK_ADDR, S_LK_CMP, S_LK_FIN, S_SI_FIN,
		S_AI_CHK, S_AI_RD0, S_AI_RD1, S_AI_SHIFT, S_AI_DIV, S_AI_WR,
		S_RC_CHK, S_RC_RD, S_DONE
	} state_t;

	state_t      state_q;
	logic [2:0]  op_q;
	logic [48:0] req_q;
	logic [7:0]  slot_q;
	logic        free_q;
	logic [5:0]  lb_q;
	logic [2:0]  nd_q;
	logic [5:0]  ld_q;
	logic        slab_q;
	logic [11:0] pages_q;

	logic [1:0]  mode_q;
	logic [31:0] hot_q;
	logic [31:0] cold_q;
	logic [12:0] quantum_q;

	logic [CW-1:0] used_q, l_q, r_q, m_q, i_q;
	logic [48:0]   size_i_q;
	logic [46:0]   align_i_q;
	logic [48:0]   mid_q;
	entry_t        rd_data_q;

	logic [1:0]  res_status_q;
	logic [7:0]  res_idx_q;
	logic [48:0] res_bytes_q;
	logic [46:0] res_align_q;
	logic [12:0] res_regs_q;

	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [7:0]  out_idx_q;
	logic [48:0] out_bytes_q;
	logic [46:0] out_align_q;
	logic [12:0] out_regs_q;
	logic [8:0]  out_entries_q;

	entry_t        ents [MAX_CLASSES];
	entry_t        rd_ent;
	ctl_t          ctl;
	logic [CW-1:0] idx_a, idx_b;
	logic [IW-1:0] rd_idx;

	logic [CW:0]   mid_sum;
	logic [CW-1:0] m_c;
	logic [CW-1:0] i_inc;
	logic          i_more;
	logic          slot_ok;
	logic          room;
	logic          hot_hit;
	logic          cold_hit;
	logic [49:0]   size_sum;
	logic [48:0]   mid_c;
	logic          div_start;
	logic          div_busy;
	logic [12:0]   div_regions;

	logic [5:0]  lb_sat, ld_sat;
	logic [49:0] app_sum;
	entry_t      app_ent;
	entry_t      mid_ent;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign found_index      = out_idx_q;
	assign class_bytes      = out_bytes_q;
	assign class_alignment  = out_align_q;
	assign regions_per_slab = out_regs_q;
	assign table_entries    = out_entries_q;

	// Search and walk helpers
	assign mid_sum  = {1'b0, l_q} + {1'b0, r_q};
	assign m_c      = mid_sum[CW:1];
	assign i_inc    = i_q + CW'(1);
	assign i_more   = ({1'b0, i_q} + (CW+1)'(1)) < {1'b0, used_q};
	assign slot_ok  = SW'(slot_q) < SW'(used_q);
	assign room     = ({1'b0, used_q} + (CW+1)'(1)) < (CW+1)'(MAX_CLASSES);
	assign hot_hit  = (rd_data_q.allocs > hot_q) && !rd_data_q.dyn && room;
	assign cold_hit = rd_data_q.dyn && (rd_data_q.allocs < cold_q)
		&& (rd_data_q.frees < cold_q);
	assign size_sum = {1'b0, size_i_q} + {1'b0, rd_data_q.size};
	assign mid_c    = size_sum[49:1];

	// Build the appended class from its exponents
	assign lb_sat  = (lb_q > LOG2_MAX) ? LOG2_MAX : lb_q;
	assign ld_sat  = (ld_q > LOG2_MAX) ? LOG2_MAX : ld_q;
	assign app_sum = (50'd1 << lb_sat) + (50'(nd_q) << ld_sat);

	always_comb begin
		app_ent.size    = app_sum[49] ? '1 : app_sum[48:0];
		app_ent.align   = 47'd1 << lb_sat;
		app_ent.regions = slab_q ? 13'(pages_q) : 13'd0;
		app_ent.allocs  = '0;
		app_ent.frees   = '0;
		app_ent.dyn     = 1'b0;
		mid_ent.size    = mid_q;
		mid_ent.align   = align_i_q;
		mid_ent.regions = div_regions;
		mid_ent.allocs  = '0;
		mid_ent.frees   = '0;
		mid_ent.dyn     = 1'b1;
	end

	// Drive the cell command and the read index from the sequencer state
	always_comb begin
		ctl.op       = CK_NONE;
		ctl.is_free  = free_q;
		ctl.clr_prev = 1'b0;
		ctl.ent      = app_ent;
		idx_a        = used_q;
		idx_b        = used_q;
		rd_idx       = IW'(i_q);
		div_start    = 1'b0;
		unique case (state_q)
			S_EXEC: begin
				rd_idx = IW'(slot_q);
				if (op_q == OP_APPEND && used_q < CW'(MAX_CLASSES)) begin
					ctl.op = CK_WRITE;
				end else if (op_q == OP_COUNT && slot_ok) begin
					ctl.op = CK_COUNT;
					idx_a  = CW'(slot_q);
				end
			end
			S_LK_ADDR: rd_idx = (l_q < r_q) ? IW'(m_c) : IW'(l_q);
			S_AI_RD0:  rd_idx = IW'(i_inc);
			S_AI_RD1:  div_start = 1'b1;
			S_AI_SHIFT: begin
				ctl.op = CK_SHR;
				idx_a  = i_q;
			end
			S_AI_WR: begin
				ctl.op       = CK_WRITE;
				ctl.clr_prev = 1'b1;
				ctl.ent      = mid_ent;
				idx_a        = i_inc;
			end
			S_RC_RD: begin
				if (cold_hit) begin
					ctl.op = CK_SHL;
					idx_a  = i_q;
					idx_b  = used_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	// Row of cells, each fed by its neighbours
	for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
		asct_cell #(
			.CW    (CW),
			.INDEX (k)
		) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.idx_a (idx_a),
			.idx_b (idx_b),
			.left  (ents[(k == 0) ? 0 : k - 1]),
			.right (ents[(k == MAX_CLASSES - 1) ? k : k + 1]),
			.ent   (ents[k])
		);
	end

	// Select the addressed cell
	always_comb begin
		rd_ent = ents[0];
		for (int k = 0; k < MAX_CLASSES; k++) begin
			if (rd_idx == IW'(k)) rd_ent = ents[k];
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= rd_ent;
	end

	asct_div #(
		.SLAB_PAGE_BYTES (SLAB_PAGE_BYTES)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (mid_c),
		.busy    (div_busy),
		.regions (div_regions)
	);

	// Sequencer, configuration and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			used_q        <= '0;
			mode_q        <= '0;
			hot_q         <= HOT_RESET;
			cold_q        <= COLD_RESET;
			quantum_q     <= QUANTUM_RESET;
			out_valid_q   <= 1'b0;
			op_q          <= '0;
			req_q         <= '0;
			slot_q        <= '0;
			free_q        <= 1'b0;
			lb_q          <= '0;
			nd_q          <= '0;
			ld_q          <= '0;
			slab_q        <= 1'b0;
			pages_q       <= '0;
			l_q           <= '0;
			r_q           <= '0;
			m_q           <= '0;
			i_q           <= '0;
			size_i_q      <= '0;
			align_i_q     <= '0;
			mid_q         <= '0;
			res_status_q  <= ST_OK;
			res_idx_q     <= '0;
			res_bytes_q   <= '0;
			res_align_q   <= '0;
			res_regs_q    <= '0;
			out_status_q  <= ST_OK;
			out_idx_q     <= '0;
			out_bytes_q   <= '0;
			out_align_q   <= '0;
			out_regs_q    <= '0;
			out_entries_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:    mode_q    <= cfg_data[1:0];
					REG_HOT:     hot_q     <= cfg_data;
					REG_COLD:    cold_q    <= cfg_data;
					REG_QUANTUM: quantum_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			// Drop the taken result word unless a new one is loaded
			if (out_valid_q && out_ready && state_q != S_DONE) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= opcode;
						req_q   <= request_size;
						slot_q  <= class_slot;
						free_q  <= event_is_free;
						lb_q    <= base_log2;
						nd_q    <= delta_count;
						ld_q    <= delta_log2;
						slab_q  <= is_slab;
						pages_q <= page_count;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_idx_q   <= '0;
					res_bytes_q <= '0;
					res_align_q <= '0;
					res_regs_q  <= '0;
					unique case (op_q)
						OP_CLEAR: begin
							used_q       <= '0;
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
						OP_APPEND: begin
							if (used_q < CW'(MAX_CLASSES)) begin
								used_q       <= used_q + CW'(1);
								res_status_q <= ST_OK;
							end else begin
								res_status_q <= ST_FULL;
							end
							state_q <= S_DONE;
						end
						OP_LOOKUP: begin
							l_q          <= '0;
							r_q          <= used_q;
							res_status_q <= ST_OK;
							state_q      <= S_LK_ADDR;
						end
						OP_SIZE: begin
							res_status_q <= slot_ok ? ST_OK : ST_RANGE;
							state_q      <= slot_ok ? S_SI_FIN : S_DONE;
						end
						OP_COUNT: begin
							res_status_q <= slot_ok ? ST_OK : ST_RANGE;
							state_q      <= S_DONE;
						end
						OP_ADAPT: begin
							i_q          <= '0;
							res_status_q <= ST_OK;
							if (mode_q == MODE_DYNAMIC || mode_q == MODE_ADAPTIVE)
								state_q <= S_AI_CHK;
							else
								state_q <= S_DONE;
						end
						default: begin
							res_status_q <= ST_OK;
							state_q      <= S_DONE;
						end
					endcase
				end
				// Binary search: each probe sets the read address, then compares the registered cell
				S_LK_ADDR: begin
					if (l_q < r_q) begin
						m_q     <= m_c;
						state_q <= S_LK_CMP;
					end else if (l_q < used_q) begin
						state_q <= S_LK_FIN;
					end else begin
						res_status_q <= ST_NOT_FOUND;
						res_align_q  <= 47'(quantum_q);
						state_q      <= S_DONE;
					end
				end
				S_LK_CMP: begin
					if (rd_data_q.size < req_q) l_q <= m_q + CW'(1);
					else r_q <= m_q;
					state_q <= S_LK_ADDR;
				end
				S_LK_FIN: begin
					res_idx_q   <= 8'(l_q);
					res_bytes_q <= rd_data_q.size;
					res_align_q <= rd_data_q.align;
					res_regs_q  <= rd_data_q.regions;
					state_q     <= S_DONE;
				end
				S_SI_FIN: begin
					res_bytes_q <= rd_data_q.size;
					state_q     <= S_DONE;
				end
				// Refine hot classes with a midpoint class
				S_AI_CHK: begin
					if (i_more) begin
						state_q <= S_AI_RD0;
					end else if (mode_q == MODE_ADAPTIVE) begin
						i_q     <= CW'(1);
						state_q <= S_RC_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_AI_RD0: begin
					if (hot_hit) begin
						size_i_q  <= rd_data_q.size;
						align_i_q <= rd_data_q.align;
						state_q   <= S_AI_RD1;
					end else begin
						i_q     <= i_inc;
						state_q <= S_AI_CHK;
					end
				end
				S_AI_RD1: begin
					mid_q   <= mid_c;
					state_q <= S_AI_SHIFT;
				end
				S_AI_SHIFT: state_q <= S_AI_DIV;
				S_AI_DIV: begin
					if (!div_busy) state_q <= S_AI_WR;
				end
				S_AI_WR: begin
					used_q  <= used_q + CW'(1);
					i_q     <= i_inc;
					state_q <= S_AI_CHK;
				end
				// Drop cold dynamic classes
				S_RC_CHK: begin
					if (i_more) state_q <= S_RC_RD;
					else state_q <= S_DONE;
				end
				S_RC_RD: begin
					if (cold_hit) used_q <= used_q - CW'(1);
					else i_q <= i_inc;
					state_q <= S_RC_CHK;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_idx_q     <= res_idx_q;
						out_bytes_q   <= res_bytes_q;
						out_align_q   <= res_align_q;
						out_regs_q    <= res_regs_q;
						out_entries_q <= 9'(used_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASCT_NEVER(a_used_bound, used_q > CW'(MAX_CLASSES), "class count above table depth")
	`ASCT_NEVER(a_div_done, state_q == S_AI_WR && div_busy, "midpoint written before divide ends")
	`ASCT_NEVER(a_insert_room, state_q == S_AI_WR && !room, "midpoint inserted into full table")
	`ASCT_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q) == S_DONE, "result without finish")

endmodule
`default_nettype wire

// ----- sim/adaptive_size_class_table_tb.sv -----
// Testbench of the size class table: queued driver, clocked monitor, built-in table predictor
`default_nettype none
module adaptive_size_class_table_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import asct_pkg::*;

	localparam int          TABLE_DEPTH = 256;
	localparam longint      CYCLE_LIMIT = 4000000;
	localparam logic [48:0] SIZE_SAT    = {49{1'b1}};
	localparam logic [2:0]  OP_SPARE6   = 3'd6;
	localparam logic [2:0]  OP_SPARE7   = 3'd7;
	localparam logic [1:0]  MODE_STATIC = 2'd0;
	localparam logic [1:0]  MODE_SPARE  = 2'd3;

	typedef struct {
		logic [2:0]  op;
		logic [48:0] req;
		logic [7:0]  slot;
		logic        evf;
		logic [5:0]  bl;
		logic [2:0]  nd;
		logic [5:0]  dl;
		logic        slab;
		logic [11:0] pages;
	} word_t;

	typedef struct {
		logic [1:0]  st;
		logic [7:0]  idx;
		logic [48:0] bytes;
		logic [46:0] algn;
		logic [12:0] regs;
		logic [8:0]  used;
	} answer_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [2:0] opcode;
	logic [48:0] request_size;
	logic [7:0] class_slot;
	logic event_is_free, is_slab;
	logic [5:0] base_log2, delta_log2;
	logic [2:0] delta_count;
	logic [11:0] page_count;
	logic [1:0] status;
	logic [7:0] found_index;
	logic [48:0] class_bytes;
	logic [46:0] class_alignment;
	logic [12:0] regions_per_slab;
	logic [8:0] table_entries;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	adaptive_size_class_table i_dut (.*);

	// Shadow table and registers
	logic [48:0] tbl_size [TABLE_DEPTH];
	logic [46:0] tbl_align [TABLE_DEPTH];
	logic [12:0] tbl_regs [TABLE_DEPTH];
	logic [31:0] tbl_alloc [TABLE_DEPTH];
	logic [31:0] tbl_free [TABLE_DEPTH];
	logic        tbl_dyn [TABLE_DEPTH];
	int unsigned tbl_used;
	logic [1:0]  sh_mode;
	logic [31:0] sh_hot, sh_cold;
	logic [12:0] sh_quantum;

	word_t   pending_words[$];
	answer_t expected_answers[$];
	word_t   drv_word;
	int      sender_idle_pct, recv_stall_pct;
	int      mismatches;
	longint  cycles;

	function automatic void move_class(int unsigned dst, int unsigned src);
		tbl_size[dst]  = tbl_size[src];
		tbl_align[dst] = tbl_align[src];
		tbl_regs[dst]  = tbl_regs[src];
		tbl_alloc[dst] = tbl_alloc[src];
		tbl_free[dst]  = tbl_free[src];
		tbl_dyn[dst]   = tbl_dyn[src];
	endfunction

	// Split hot classes with a midpoint class
	function automatic void refine_hot();
		int unsigned i;
		logic [63:0] mid, reg_n;
		i = 0;
		while (i + 1 < tbl_used) begin
			if (tbl_alloc[i] > sh_hot && !tbl_dyn[i] && tbl_used + 1 < TABLE_DEPTH) begin
				mid = ({15'd0, tbl_size[i]} + {15'd0, tbl_size[i+1]}) >> 1;
				reg_n = 0;
				for (int unsigned k = tbl_used; k > i + 1; k--)
					move_class(k, k - 1);
				if (mid != 0) begin
					reg_n = 64'(DEF_SLAB_PAGE_BYTES) / mid;
					if (reg_n > 64'(REGION_MAX))
						reg_n = 64'(REGION_MAX);
				end
				tbl_size[i+1]  = mid[48:0];
				tbl_align[i+1] = tbl_align[i];
				tbl_regs[i+1]  = reg_n[12:0];
				tbl_alloc[i+1] = 0;
				tbl_free[i+1]  = 0;
				tbl_dyn[i+1]   = 1'b1;
				tbl_used++;
				tbl_alloc[i] = 0;
			end
			i++;
		end
	endfunction

	// Drop cold dynamic classes, never the first or last
	function automatic void drop_cold();
		int unsigned i;
		i = 1;
		while (i + 1 < tbl_used) begin
			if (tbl_dyn[i] && tbl_alloc[i] < sh_cold && tbl_free[i] < sh_cold) begin
				for (int unsigned k = i; k + 1 < tbl_used; k++)
					move_class(k, k + 1);
				tbl_used--;
			end else
				i++;
		end
	endfunction

	function automatic answer_t table_answer(word_t w);
		answer_t a;
		int unsigned lo, hi, m;
		logic [5:0] lb, ld;
		logic [63:0] sz;
		a = '{default: '0};
		case (w.op)
			OP_CLEAR: tbl_used = 0;
			OP_APPEND: begin
				if (tbl_used >= TABLE_DEPTH)
					a.st = ST_FULL;
				else begin
					lb = (w.bl > LOG2_MAX) ? LOG2_MAX : w.bl;
					ld = (w.dl > LOG2_MAX) ? LOG2_MAX : w.dl;
					sz = (64'd1 << lb) + (64'(w.nd) << ld);
					if (sz > 64'(SIZE_SAT))
						sz = 64'(SIZE_SAT);
					tbl_size[tbl_used]  = sz[48:0];
					tbl_align[tbl_used] = 47'd1 << lb;
					tbl_regs[tbl_used]  = w.slab ? {1'b0, w.pages} : 13'd0;
					tbl_alloc[tbl_used] = 0;
					tbl_free[tbl_used]  = 0;
					tbl_dyn[tbl_used]   = 1'b0;
					tbl_used++;
				end
			end
			OP_LOOKUP: begin
				lo = 0;
				hi = tbl_used;
				while (lo < hi) begin
					m = (lo + hi) >> 1;
					if (tbl_size[m] < w.req)
						lo = m + 1;
					else
						hi = m;
				end
				if (lo < tbl_used) begin
					a.idx = lo[7:0];
					a.bytes = tbl_size[lo];
					a.algn = tbl_align[lo];
					a.regs = tbl_regs[lo];
				end else begin
					a.st = ST_NOT_FOUND;
					a.algn = {34'd0, sh_quantum};
				end
			end
			OP_SIZE: begin
				if (w.slot < tbl_used)
					a.bytes = tbl_size[w.slot];
				else
					a.st = ST_RANGE;
			end
			OP_COUNT: begin
				if (w.slot >= tbl_used)
					a.st = ST_RANGE;
				else if (w.evf) begin
					if (tbl_free[w.slot] != '1)
						tbl_free[w.slot]++;
				end else if (tbl_alloc[w.slot] != '1)
					tbl_alloc[w.slot]++;
			end
			OP_ADAPT: begin
				if (sh_mode == MODE_DYNAMIC)
					refine_hot();
				else if (sh_mode == MODE_ADAPTIVE) begin
					refine_hot();
					drop_cold();
				end
			end
			default: ;
		endcase
		a.used = tbl_used[8:0];
		return a;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("t=%0t %s: got %0h, want %0h", $realtime, field, got, want);
		mismatches++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Drive input words from the queue, with random idling
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_answers.push_back(table_answer(drv_word));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					drv_word = pending_words.pop_front();
					in_valid      <= 1'b1;
					opcode        <= drv_word.op;
					request_size  <= drv_word.req;
					class_slot    <= drv_word.slot;
					event_is_free <= drv_word.evf;
					base_log2     <= drv_word.bl;
					delta_count   <= drv_word.nd;
					delta_log2    <= drv_word.dl;
					is_slab       <= drv_word.slab;
					page_count    <= drv_word.pages;
				end else
					in_valid <= 1'b0;
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_answers.size() == 0)
				report_mismatch("unexpected result", table_entries, 0);
			else begin
				e = expected_answers.pop_front();
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (found_index !== e.idx) report_mismatch("found_index", found_index, e.idx);
				if (class_bytes !== e.bytes) report_mismatch("class_bytes", class_bytes, e.bytes);
				if (class_alignment !== e.algn)
					report_mismatch("class_alignment", class_alignment, e.algn);
				if (regions_per_slab !== e.regs)
					report_mismatch("regions_per_slab", regions_per_slab, e.regs);
				if (table_entries !== e.used)
					report_mismatch("table_entries", table_entries, e.used);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic word_t noise_word();
		word_t w;
		w.op = 3'($urandom);
		w.req = {17'($urandom), 32'($urandom)};
		w.slot = 8'($urandom);
		w.evf = 1'($urandom);
		w.bl = 6'($urandom);
		w.nd = 3'($urandom);
		w.dl = 6'($urandom);
		w.slab = 1'($urandom);
		w.pages = 12'($urandom);
		return w;
	endfunction

	function automatic void queue_op(logic [2:0] op, logic [48:0] req = 0, logic [7:0] slot = 0,
			logic evf = 0);
		word_t w;
		w = noise_word();
		w.op = op;
		w.req = req;
		w.slot = slot;
		w.evf = evf;
		pending_words.push_back(w);
	endfunction

	function automatic void queue_append(logic [5:0] bl, logic [2:0] nd, logic [5:0] dl,
			logic slab, logic [11:0] pages);
		word_t w;
		w = noise_word();
		w.op = OP_APPEND;
		w.bl = bl;
		w.nd = nd;
		w.dl = dl;
		w.slab = slab;
		w.pages = pages;
		pending_words.push_back(w);
	endfunction

	// Clear, build a sorted table, then exercise it with mostly sensible traffic
	function automatic void queue_session(int n_classes, int n_ops);
		logic [63:0] sizes[$];
		int start, g, pick, r;
		logic [5:0] bl;
		logic [2:0] nd;
		logic [63:0] req;
		queue_op(OP_CLEAR);
		start = $urandom_range(2, 12);
		for (int j = 0; j < n_classes; j++) begin
			g = start + j / 4;
			bl = (g > 63) ? 6'd63 : 6'(g);
			nd = 3'(j % 4);
			queue_append(bl, nd, (bl < 2) ? 6'd0 : bl - 6'd2, 1'($urandom), 12'($urandom));
			sizes.push_back(64'd1 << bl);
		end
		for (int j = 0; j < n_ops; j++) begin
			r = $urandom_range(99);
			pick = $urandom_range(n_classes);
			if (r < 35) begin
				req = (pick < n_classes) ? sizes[pick] + 64'($urandom_range(0, 6)) - 64'd3
					: {15'd0, 17'($urandom), 32'($urandom)};
				queue_op(OP_LOOKUP, req[48:0]);
			end else if (r < 48)
				queue_op(OP_SIZE, 0, 8'(pick));
			else if (r < 78)
				queue_op(OP_COUNT, 0, 8'(pick % (n_classes / 2 + 1)));
			else if (r < 88)
				queue_op(OP_COUNT, 0, 8'(pick), 1'b1);
			else if (r < 94)
				queue_op(OP_ADAPT);
			else
				pending_words.push_back(noise_word());
		end
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODE:    sh_mode = data[1:0];
			REG_HOT:     sh_hot = data;
			REG_COLD:    sh_cold = data;
			REG_QUANTUM: sh_quantum = data[12:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [1:0] mode, logic [31:0] hot, logic [31:0] cold,
			logic [12:0] quantum);
		write_reg(REG_MODE, {30'd0, mode});
		write_reg(REG_HOT, hot);
		write_reg(REG_COLD, cold);
		write_reg(REG_QUANTUM, {19'd0, quantum});
	endtask

	task automatic drain();
		wait (pending_words.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_phase(int idle, int stall, int words);
		int target;
		sender_idle_pct = idle;
		recv_stall_pct = stall;
		target = pending_words.size() + words;
		while (pending_words.size() < target) begin
			if ($urandom_range(9) == 0)
				queue_session($urandom_range(2, 40), $urandom_range(20, 60));
			else
				queue_session($urandom_range(2, 12), $urandom_range(10, 40));
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		opcode = OP_CLEAR;
		request_size = '0;
		class_slot = '0;
		event_is_free = 1'b0;
		base_log2 = '0;
		delta_count = '0;
		delta_log2 = '0;
		is_slab = 1'b0;
		page_count = '0;
		mismatches = 0;
		cycles = 0;
		tbl_used = 0;
		sh_mode = MODE_STATIC;
		sh_hot = HOT_RESET;
		sh_cold = COLD_RESET;
		sh_quantum = QUANTUM_RESET;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed corners under reset registers
		queue_op(OP_LOOKUP, 49'd5);
		queue_op(OP_SIZE, 0, 8'd0);
		queue_op(OP_COUNT, 0, 8'd0);
		queue_append(6'd0, 3'd0, 6'd0, 1'b1, 12'hFFF);
		queue_append(6'd4, 3'd7, 6'd63, 1'b1, 12'd0);
		queue_append(6'd63, 3'd7, 6'd63, 1'b0, 12'hFFF);
		queue_append(6'd10, 3'd1, 6'd2, 1'b1, 12'd7);
		queue_op(OP_LOOKUP, 49'd0);
		queue_op(OP_LOOKUP, 49'd2);
		queue_op(OP_LOOKUP, 49'd5000);
		queue_op(OP_LOOKUP, SIZE_SAT);
		queue_op(OP_SIZE, 0, 8'd1);
		queue_op(OP_SIZE, 0, 8'd255);
		queue_op(OP_COUNT, 0, 8'd0, 1'b0);
		queue_op(OP_COUNT, 0, 8'd0, 1'b1);
		queue_op(OP_COUNT, 0, 8'd255, 1'b1);
		queue_op(OP_SPARE6, SIZE_SAT, 8'hFF, 1'b1);
		queue_op(OP_SPARE7);
		queue_op(OP_ADAPT);
		queue_op(OP_CLEAR);
		queue_op(OP_LOOKUP, 49'd1);
		drain();

		set_regs(MODE_DYNAMIC, 32'd0, 32'hFFFF_FFFF, 13'd1);
		random_phase(80, 0, 200);

		// Fill to capacity: one refinement, then the full table
		queue_session(254, 0);
		queue_op(OP_COUNT, 0, 8'd0);
		queue_op(OP_ADAPT);
		queue_op(OP_ADAPT);
		queue_append(6'd46, 3'd7, 6'd46, 1'b1, 12'd1);
		queue_append(6'd1, 3'd0, 6'd0, 1'b1, 12'd2);
		queue_op(OP_LOOKUP, SIZE_SAT);
		queue_op(OP_SIZE, 0, 8'd255);
		queue_op(OP_COUNT, 0, 8'd255, 1'b1);
		drain();

		set_regs(MODE_ADAPTIVE, 32'd2, 32'd3, 13'd4096);
		random_phase(0, 80, 200);
		set_regs(MODE_SPARE, 32'hFFFF_FFFF, 32'd0, 13'd8191);
		random_phase(17, 17, 150);
		set_regs(MODE_ADAPTIVE, 32'd0, 32'hFFFF_FFFF, 13'd0);
		random_phase(0, 0, 150);
		set_regs(MODE_DYNAMIC, 32'd1, 32'd10, 13'd64);
		random_phase(17, 17, 150);

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
